[hdl/hemt_pkg.sv]
// Shared constants, types and helpers of the half-ellipse mask tessellator.
// Used by every module of the block; depends on nothing.
package hemt_pkg;

  localparam int SEG_W           = 10;
  localparam int MIN_SEGMENTS    = 2;
  localparam int IN_W            = 16;
  localparam int IN_FRAC         = 12;
  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 14;
  localparam int FRAC_Q          = 30;

  // long division of 2k * 2^30 by segments - 1
  localparam int NUM_W         = SEG_W + 1;
  localparam int DIV_BITS      = NUM_W + FRAC_Q;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int QUO_W         = FRAC_Q + 2;

  // angle and series arithmetic
  localparam int ANG_W        = 31;
  localparam int V_W          = 32;
  localparam int HORNER_TERMS = 7;
  localparam int HS           = 3 * HORNER_TERMS;
  localparam logic [ANG_W-1:0] ONE_Q30     = ANG_W'(1) << FRAC_Q;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  // point arithmetic
  localparam int PT_W      = 48;
  localparam int PT_FRAC   = FRAC_Q + IN_FRAC;
  localparam int RND_SHIFT = PT_FRAC - COORD_FRAC_BITS;
  localparam logic signed [PT_W-1:0] ONE_PT  = PT_W'(1) <<< PT_FRAC;
  localparam logic signed [PT_W-1:0] RND_ADD = PT_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [COORD_W-1:0] FAR_POS = COORD_W'(65000 * (1 << COORD_FRAC_BITS));
  localparam logic signed [COORD_W-1:0] FAR_NEG = -FAR_POS;

  typedef enum logic [2:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_RADIUS_X,
    CFG_RADIUS_Y,
    CFG_SEGMENTS,
    CFG_SWEEP_DIR,
    CFG_FILL_DIR,
    CFG_EYE_INDEX
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_A,
    EMIT_B,
    EMIT_FAR
  } emit_state_e;

  typedef struct packed {
    logic signed [IN_W-1:0] center_x;
    logic signed [IN_W-1:0] center_y;
    logic signed [IN_W-1:0] radius_x;
    logic signed [IN_W-1:0] radius_y;
    logic [SEG_W-1:0]       seg_n;
    logic [SEG_W-1:0]       seg_n1;
    logic                   sweep_dir;
    logic                   fill_dir;
    logic                   eye_index;
  } cfg_t;

  typedef struct packed {
    logic first;
    logic final_seg;
  } seg_flags_t;

  typedef struct packed {
    logic [SEG_W-1:0] rem;
    logic [NUM_W-1:0] dvd;
    logic [QUO_W-1:0] quo;
  } div_state_t;

  typedef struct packed {
    logic [1:0]       quad;
    logic [ANG_W-1:0] x;
    logic [V_W-1:0]   x2;
  } ang_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      hit;
    seg_flags_t                flags;
  } tri_t;

  // Divisor of Horner term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic int horner_div(int k, logic odd);
    return odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
  endfunction

endpackage

[hdl/hemt_divider.sv]
// Index clamp and pipelined restoring divider, two lanes (points A and B).
// Depends on hemt_pkg; produces quadrant and quarter-turn fraction per point.
module hemt_divider import hemt_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  logic [SEG_W-1:0]            step_index_i,
  input  cfg_t                        cfg_i,
  output logic                        out_valid_o,
  output seg_flags_t                  out_flags_o,
  output logic [1:0][QUO_W-1:0]       out_quo_o
);

  div_state_t st_q [DIV_STAGES+1][2];
  seg_flags_t flg_q [DIV_STAGES+1];
  logic [DIV_STAGES:0] vld_q;

  logic [SEG_W-1:0] idx_c;
  logic [SEG_W-1:0] ka_c;

  function automatic div_state_t div_step(div_state_t st, logic [SEG_W-1:0] dsr, int nst);
    div_state_t o;
    logic [SEG_W:0] trial;
    o = st;
    for (int j = 0; j < DIV_PER_STAGE; j++) begin
      if (j < nst) begin
        trial = {o.rem, o.dvd[NUM_W-1]};
        o.dvd = {o.dvd[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr}) begin
          o.rem = SEG_W'(trial - {1'b0, dsr});
          o.quo = {o.quo[QUO_W-2:0], 1'b1};
        end else begin
          o.rem = trial[SEG_W-1:0];
          o.quo = {o.quo[QUO_W-2:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  // Clamp the index and pick the two angle indexes
  always_comb begin
    idx_c = (step_index_i > cfg_i.seg_n) ? cfg_i.seg_n : step_index_i;
    ka_c  = (idx_c == '0) ? '0 : idx_c - 1'b1;
  end

  // Load the dividends
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0][0] <= '{rem: '0, dvd: {ka_c, 1'b0}, quo: '0};
      st_q[0][1] <= '{rem: '0, dvd: {idx_c, 1'b0}, quo: '0};
      flg_q[0]   <= '{first: (idx_c == '0), final_seg: (idx_c == cfg_i.seg_n)};
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-1:0], in_valid_i};
    end
  end

  // Two quotient bits per stage, one in the last stage
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    localparam int LEFT = DIV_BITS - (s - 1) * DIV_PER_STAGE;
    localparam int NST  = (LEFT < DIV_PER_STAGE) ? LEFT : DIV_PER_STAGE;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s][0] <= div_step(st_q[s-1][0], cfg_i.seg_n1, NST);
        st_q[s][1] <= div_step(st_q[s-1][1], cfg_i.seg_n1, NST);
        flg_q[s]   <= flg_q[s-1];
      end
    end
  end

  assign out_valid_o  = vld_q[DIV_STAGES];
  assign out_flags_o  = flg_q[DIV_STAGES];
  assign out_quo_o[0] = st_q[DIV_STAGES][0].quo;
  assign out_quo_o[1] = st_q[DIV_STAGES][1].quo;

endmodule

[hdl/hemt_sincos.sv]
// Residual angle, Horner series for sine and cosine, quadrant and sweep sign.
// Depends on hemt_pkg; fed by hemt_divider, feeds hemt_point.
module hemt_sincos import hemt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_valid_i,
  input  seg_flags_t              in_flags_i,
  input  logic [1:0][QUO_W-1:0]   in_quo_i,
  input  logic                    sweep_dir_i,
  output logic                    out_valid_o,
  output seg_flags_t              out_flags_o,
  output logic [1:0][COORD_W-1:0] out_sin_o,
  output logic [1:0][COORD_W-1:0] out_cos_o
);

  localparam int DEPTH = HS + 4;

  logic [DEPTH-1:0] vld_q;
  seg_flags_t       flg_q [DEPTH];

  logic [1:0]       quad1_q [2];
  logic [ANG_W-1:0] x1_q [2];
  ang_t             car_q [HS+1][2];

  logic [ANG_W-1:0]   t_q  [HORNER_TERMS][2][2];
  logic [V_W-1:0]     v_q  [HORNER_TERMS][2][2];
  logic [V_W-1:0]     vd_q [HORNER_TERMS][2][2];
  logic [2*V_W-1:0]   m_q  [HORNER_TERMS][2][2];

  logic [1:0]         quads_q [2];
  logic [ANG_W-1:0]   sv_q [2];
  logic [ANG_W-1:0]   cv_q [2];
  logic [COORD_W-1:0] sin_q [2];
  logic [COORD_W-1:0] cos_q [2];

  // Advance valid bits and segment flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0] <= in_flags_i;
      for (int k = 1; k < DEPTH; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [QUO_W-2+ANG_W-1:0] px_c;
    logic [2*ANG_W-1:0]       x2_c;
    logic [2*ANG_W-1:0]       ps_c;
    logic signed [COORD_W-1:0] s_c;
    logic signed [COORD_W-1:0] c_c;
    logic signed [COORD_W-1:0] sn_c;
    logic signed [COORD_W-1:0] cs_c;

    // Scale the quarter-turn fraction to radians, then square
    assign px_c = in_quo_i[l][FRAC_Q-1:0] * HALF_PI_Q30;
    assign x2_c = x1_q[l] * x1_q[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad1_q[l]    <= in_quo_i[l][QUO_W-1:FRAC_Q];
        x1_q[l]       <= px_c[FRAC_Q +: ANG_W];
        car_q[0][l]   <= '{quad: quad1_q[l], x: x1_q[l], x2: x2_c[FRAC_Q +: V_W]};
      end
    end

    // Carry the angle alongside the series stages
    for (genvar j = 1; j <= HS; j++) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          car_q[j][l] <= car_q[j-1][l];
        end
      end
    end

    // Horner series: chain 0 is sine, chain 1 is cosine
    for (genvar g = 0; g < HORNER_TERMS; g++) begin : g_term
      for (genvar c = 0; c < 2; c++) begin : g_chain
        localparam int D  = horner_div(HORNER_TERMS - g, c == 0);
        localparam int SH = V_W - 2 + $clog2(D + 1);
        localparam logic [V_W-1:0] M = V_W'((64'd1 << SH) / D);

        logic [ANG_W-1:0]     t_in;
        logic [V_W+ANG_W-1:0] pa_c;
        logic [V_W-1:0]       q0_c;
        logic [V_W-1:0]       rem_c;
        logic [V_W-1:0]       sub_c;
        logic [ANG_W-1:0]     t_d;

        if (g == 0) begin : g_seed
          assign t_in = ONE_Q30;
        end else begin : g_link
          assign t_in = t_q[g-1][l][c];
        end

        assign pa_c = car_q[3*g][l].x2 * t_in;

        // Divide by the term constant: reciprocal product plus one correction
        always_comb begin
          q0_c  = V_W'(m_q[g][l][c] >> SH);
          rem_c = vd_q[g][l][c] - V_W'(q0_c * D);
          sub_c = (rem_c >= V_W'(D)) ? q0_c + 1'b1 : q0_c;
          t_d   = (sub_c >= V_W'(ONE_Q30)) ? '0 : ANG_W'(V_W'(ONE_Q30) - sub_c);
        end

        always_ff @(posedge clk_i) begin
          if (en_i) begin
            v_q[g][l][c]  <= pa_c[FRAC_Q +: V_W];
            vd_q[g][l][c] <= v_q[g][l][c];
            m_q[g][l][c]  <= v_q[g][l][c] * M;
            t_q[g][l][c]  <= t_d;
          end
        end
      end
    end

    // Sine needs one more factor of x
    assign ps_c = car_q[HS][l].x * t_q[HORNER_TERMS-1][l][0];

    // Map to the quadrant and apply the sweep sign
    always_comb begin
      s_c = COORD_W'({1'b0, sv_q[l]});
      c_c = COORD_W'({1'b0, cv_q[l]});
      case (quads_q[l])
        2'd0: begin sn_c = s_c;  cs_c = c_c;  end
        2'd1: begin sn_c = c_c;  cs_c = -s_c; end
        2'd2: begin sn_c = -s_c; cs_c = -c_c; end
        default: begin sn_c = -c_c; cs_c = s_c; end
      endcase
      if (sweep_dir_i) begin
        sn_c = -sn_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quads_q[l] <= car_q[HS][l].quad;
        sv_q[l]    <= ps_c[FRAC_Q +: ANG_W];
        cv_q[l]    <= t_q[HORNER_TERMS-1][l][1];
        sin_q[l]   <= sn_c;
        cos_q[l]   <= cs_c;
      end
    end

    assign out_sin_o[l] = sin_q[l];
    assign out_cos_o[l] = cos_q[l];
  end

  assign out_valid_o = vld_q[DEPTH-1];
  assign out_flags_o = flg_q[DEPTH-1];

endmodule

[hdl/hemt_point.sv]
// Ellipse point forming, unit square test and rounding to output format.
// Depends on hemt_pkg; fed by hemt_sincos, feeds hemt_emit.
module hemt_point import hemt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_valid_i,
  input  seg_flags_t              in_flags_i,
  input  logic [1:0][COORD_W-1:0] in_sin_i,
  input  logic [1:0][COORD_W-1:0] in_cos_i,
  input  cfg_t                    cfg_i,
  output logic                    out_valid_o,
  output tri_t                    out_tri_o
);

  logic [2:0]  vld_q;
  seg_flags_t  flg_q [2];

  logic signed [PT_W-1:0] mx_q [2];
  logic signed [PT_W-1:0] my_q [2];
  logic signed [PT_W-1:0] px_q [2];
  logic signed [PT_W-1:0] py_q [2];
  tri_t                   tri_q;

  logic [1:0]                in_sq_c;
  logic signed [COORD_W-1:0] rx_c [2];
  logic signed [COORD_W-1:0] ry_c [2];

  function automatic logic [COORD_W-1:0] round_out(logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] s;
    s = (v + RND_ADD) >>> RND_SHIFT;
    return s[COORD_W-1:0];
  endfunction

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  // Scale by the radii, then add the center
  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mx_q[l] <= PT_W'($signed(in_sin_i[l])) * PT_W'(cfg_i.radius_x);
        my_q[l] <= PT_W'($signed(in_cos_i[l])) * PT_W'(cfg_i.radius_y);
        px_q[l] <= mx_q[l] + (PT_W'(cfg_i.center_x) <<< FRAC_Q);
        py_q[l] <= my_q[l] + (PT_W'(cfg_i.center_y) <<< FRAC_Q);
      end
    end

    always_comb begin
      in_sq_c[l] = (px_q[l] >= -ONE_PT) && (px_q[l] <= ONE_PT) &&
                   (py_q[l] >= -ONE_PT) && (py_q[l] <= ONE_PT);
      rx_c[l]    = round_out(px_q[l]);
      ry_c[l]    = round_out(py_q[l]);
    end
  end

  // Test the square and round both points
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0]  <= in_flags_i;
      flg_q[1]  <= flg_q[0];
      tri_q     <= '{ax: rx_c[0], ay: ry_c[0], bx: rx_c[1], by: ry_c[1],
                     hit: |in_sq_c, flags: flg_q[1]};
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_tri_o   = tri_q;

endmodule

[hdl/hemt_emit.sv]
// Output sequencer: holds one triangle and sends its three vertices.
// Depends on hemt_pkg; its take signal stalls the whole pipeline.
module hemt_emit import hemt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  tri_t                      in_tri_i,
  input  cfg_t                      cfg_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] vert_x_o,
  output logic signed [COORD_W-1:0] vert_y_o,
  output logic                      eye_o,
  output logic                      last_o
);

  emit_state_e state_q, state_d;
  tri_t        tri_q;
  logic        load_c;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EMIT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture a triangle
  always_ff @(posedge clk_i) begin
    if (load_c) begin
      tri_q <= in_tri_i;
    end
  end

  // Step through the vertices; drop items that miss the square
  always_comb begin
    state_d     = state_q;
    take_o      = 1'b0;
    load_c      = 1'b0;
    out_valid_o = 1'b1;
    last_o      = 1'b0;
    vert_x_o    = tri_q.ax;
    vert_y_o    = tri_q.flags.first ? FAR_POS : tri_q.ay;
    case (state_q)
      EMIT_IDLE: begin
        out_valid_o = 1'b0;
        take_o      = 1'b1;
        if (in_valid_i && in_tri_i.hit) begin
          load_c  = 1'b1;
          state_d = EMIT_A;
        end
      end
      EMIT_A: begin
        if (out_ready_i) begin
          state_d = EMIT_B;
        end
      end
      EMIT_B: begin
        vert_x_o = tri_q.flags.final_seg ? tri_q.ax : tri_q.bx;
        vert_y_o = tri_q.flags.final_seg ? FAR_NEG : tri_q.by;
        if (out_ready_i) begin
          state_d = EMIT_FAR;
        end
      end
      EMIT_FAR: begin
        vert_x_o = cfg_i.fill_dir ? FAR_NEG : FAR_POS;
        vert_y_o = tri_q.ay;
        last_o   = 1'b1;
        if (out_ready_i) begin
          take_o = 1'b1;
          if (in_valid_i && in_tri_i.hit) begin
            load_c  = 1'b1;
            state_d = EMIT_A;
          end else begin
            state_d = EMIT_IDLE;
          end
        end
      end
      default: begin
        out_valid_o = 1'b0;
        state_d     = EMIT_IDLE;
      end
    endcase
  end

  assign eye_o = cfg_i.eye_index;

`ifndef SYNTHESIS
  a_take_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && out_valid_o) |-> (last_o && out_ready_i))
    else $error("pipeline advanced while a triangle was still pending");

  a_start_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !last_o)
    else $error("triangle started on its closing vertex");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && in_valid_i && in_tri_i.hit) |=> (out_valid_o && !last_o))
    else $error("captured triangle did not start on the output");
`endif

endmodule

[hdl/half_ellipse_mask_tessellator_unit.sv]
// Half-ellipse mask tessellator, top level: configuration registers and pipeline.
// Depends on hemt_pkg, hemt_divider, hemt_sincos, hemt_point and hemt_emit.
//
// Usage: write the eight configuration registers through cfg_we_i/cfg_addr_i/
// cfg_wdata_i while the block is idle. Each step_index transaction on the input
// channel (in_valid_i/in_ready_o) yields either three vertex transactions on the
// output channel (out_valid_o/out_ready_i, last_o on the third) or none, when
// neither end point of the segment lies in the unit square.
// The datapath holds the 21-stage divider (two quotient bits per stage, one in
// the last stage) and the seven Horner terms of three stages each.
// Throughput: one index per cycle while indexes produce no triangle; when each
// produces one, the next index waits until the single output port has sent all three vertices.
// Reset clears all valid bits, returns the sequencer to idle and loads the
// register reset values (segments = 2, all others 0).
// When the receiver stalls, the whole pipeline holds in place and in_ready_o
// drops; nothing is lost or repeated.
module half_ellipse_mask_tessellator_unit import hemt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_addr_i,
  input  logic [IN_W-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SEG_W-1:0]          step_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] vert_x_o,
  output logic signed [COORD_W-1:0] vert_y_o,
  output logic                      eye_o,
  output logic                      last_o
);

  logic signed [IN_W-1:0] center_x_q, center_y_q, radius_x_q, radius_y_q;
  logic [SEG_W-1:0]       segments_q;
  logic                   sweep_dir_q, fill_dir_q, eye_index_q;

  cfg_t             cfg_c;
  logic [SEG_W-1:0] seg_n_c;
  logic             en;

  logic                    div_valid;
  seg_flags_t              div_flags;
  logic [1:0][QUO_W-1:0]   div_quo;
  logic                    sc_valid;
  seg_flags_t              sc_flags;
  logic [1:0][COORD_W-1:0] sc_sin, sc_cos;
  logic                    pt_valid;
  tri_t                    pt_tri;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      radius_x_q  <= '0;
      radius_y_q  <= '0;
      segments_q  <= SEG_W'(MIN_SEGMENTS);
      sweep_dir_q <= 1'b0;
      fill_dir_q  <= 1'b0;
      eye_index_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_CENTER_X:  center_x_q  <= cfg_wdata_i;
        CFG_CENTER_Y:  center_y_q  <= cfg_wdata_i;
        CFG_RADIUS_X:  radius_x_q  <= cfg_wdata_i;
        CFG_RADIUS_Y:  radius_y_q  <= cfg_wdata_i;
        CFG_SEGMENTS:  segments_q  <= cfg_wdata_i[SEG_W-1:0];
        CFG_SWEEP_DIR: sweep_dir_q <= cfg_wdata_i[0];
        CFG_FILL_DIR:  fill_dir_q  <= cfg_wdata_i[0];
        CFG_EYE_INDEX: eye_index_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the segment count and bundle the configuration
  always_comb begin
    seg_n_c = (segments_q < SEG_W'(MIN_SEGMENTS)) ? SEG_W'(MIN_SEGMENTS) : segments_q;
    cfg_c   = '{center_x: center_x_q, center_y: center_y_q,
                radius_x: radius_x_q, radius_y: radius_y_q,
                seg_n: seg_n_c, seg_n1: seg_n_c - 1'b1,
                sweep_dir: sweep_dir_q, fill_dir: fill_dir_q,
                eye_index: eye_index_q};
  end

  assign in_ready_o = en;

  hemt_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .step_index_i (step_index_i),
    .cfg_i        (cfg_c),
    .out_valid_o  (div_valid),
    .out_flags_o  (div_flags),
    .out_quo_o    (div_quo)
  );

  hemt_sincos u_sincos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (div_valid),
    .in_flags_i  (div_flags),
    .in_quo_i    (div_quo),
    .sweep_dir_i (cfg_c.sweep_dir),
    .out_valid_o (sc_valid),
    .out_flags_o (sc_flags),
    .out_sin_o   (sc_sin),
    .out_cos_o   (sc_cos)
  );

  hemt_point u_point (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sc_valid),
    .in_flags_i  (sc_flags),
    .in_sin_i    (sc_sin),
    .in_cos_i    (sc_cos),
    .cfg_i       (cfg_c),
    .out_valid_o (pt_valid),
    .out_tri_o   (pt_tri)
  );

  hemt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pt_valid),
    .in_tri_i    (pt_tri),
    .cfg_i       (cfg_c),
    .take_o      (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vert_x_o    (vert_x_o),
    .vert_y_o    (vert_y_o),
    .eye_o       (eye_o),
    .last_o      (last_o)
  );

endmodule
